/* hw/rtl/cnv_pkg.sv */
// Shared types and constants of the 3x3 saturating convolution filter.
`timescale 1ns / 1ps

package cnv_pkg;

    // Field and register widths.
    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int ROI_W   = 27;
    localparam int COEF_W  = 16;
    localparam int KERN_W  = 48;
    localparam int TAPS    = 9;
    localparam int CFG_IDX_W = 3;

    // Arithmetic widths: a 16 x 9 bit signed product, and a sum of nine of them.
    localparam int PROD_W  = COEF_W + PIX_W + 1;
    localparam int SUM_W   = PROD_W + 4;
    localparam int PIX_MAX = 255;

    // Queue depths between the stages and in front of the result port.
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_LVL_W = $clog2(JOBQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW2  = 3'd6;

    // Frame geometry as written by software.
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [ROI_W-1:0]  roi_x;
        logic [ROI_W-1:0]  roi_y;
    } t_geom;

    // Three kernel rows, top row at index 0.
    typedef logic [2:0][KERN_W-1:0] t_kernel;

    // One classified window waiting for the arithmetic.
    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] win;
        logic [POS_W-1:0]           col;
        logic [POS_W-1:0]           row;
        logic                       last;
    } t_job;

    // One finished result.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } t_res;

endpackage

/* hw/rtl/conv3x3_saturating_filter.sv */
// Top level of the 3x3 saturating convolution filter: configuration and stage wiring.
//
//   Channel   Direction  Handshake               Payload
//   pixels    in         push / full             i_pixel_in, i_frame_start
//   results   out        empty / pop             o_pixel_out, o_out_col, o_out_row,
//                                                o_last_of_frame
//   config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// One pixel is taken every clock while full is low; it goes through stage A, the job
// queue, stages P and R and the result queue, with the line store read port and the
// product stage each used once per item. Reset is synchronous; the line stores are not
// cleared, so rows 0 and 1 of the first frame only fill them.
// full rises when the job queue, with the item in the window stage, would be full; the
// arithmetic stops taking jobs when the result queue plus its two stages is committed.
`timescale 1ns / 1ps

module conv3x3_saturating_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cnv_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [cnv_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [cnv_pkg::POS_W-1:0]     o_out_col,
    output logic [cnv_pkg::POS_W-1:0]     o_out_row,
    output logic                          o_last_of_frame,
    input  logic                          i_cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cnv_pkg::KERN_W-1:0]    i_cfg_data
);

    import cnv_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] r_image_width;
    logic [SIZE_W-1:0] r_image_height;
    logic [ROI_W-1:0]  r_roi_x;
    logic [ROI_W-1:0]  r_roi_y;
    t_kernel           r_kernel;

    t_geom                  geom;
    logic                   job_push;
    t_job                   job_in;
    t_job                   job_out;
    logic                   job_empty;
    logic                   job_full;
    logic                   job_pop;
    logic [JOBQ_LVL_W-1:0]  job_level;
    t_res                   res;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SIZE_W'(256);
            r_image_height <= SIZE_W'(256);
            r_roi_x        <= ROI_W'(16777216);
            r_roi_y        <= ROI_W'(16777216);
            r_kernel       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[SIZE_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[SIZE_W-1:0];
                end
                REG_ROI_X: begin
                    r_roi_x <= i_cfg_data[ROI_W-1:0];
                end
                REG_ROI_Y: begin
                    r_roi_y <= i_cfg_data[ROI_W-1:0];
                end
                REG_KERNEL_ROW0: begin
                    r_kernel[0] <= i_cfg_data;
                end
                REG_KERNEL_ROW1: begin
                    r_kernel[1] <= i_cfg_data;
                end
                REG_KERNEL_ROW2: begin
                    r_kernel[2] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom.width  = r_image_width;
        geom.height = r_image_height;
        geom.roi_x  = r_roi_x;
        geom.roi_y  = r_roi_y;
    end

    // Front end: positions, line stores, window.
    cnv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_geom        (geom),
        .i_q_level     (job_level),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    // Job queue between the window and the arithmetic.
    cnv_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_full  (job_full),
        .o_level (job_level)
    );

    // Back end: weighted sum, clamp, result queue.
    cnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_kernel    (r_kernel),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_pixel_out     = res.pixel;
    assign o_out_col       = res.col;
    assign o_out_row       = res.row;
    assign o_last_of_frame = res.last;

    // The front end's own level check means no push ever meets a full job queue.
    a_jobq_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full) else $error("conv3x3: job queue overrun");

endmodule

/* hw/rtl/cnv_fifo.sv */
// Small synchronous queue with a fill level output.
`timescale 1ns / 1ps

module cnv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [LW-1:0]    r_level;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == LW'(DEPTH));
    assign o_level = r_level;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage of the queued items.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // The stages around the queue must never push into a full queue or pop an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("cnv_fifo: push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("cnv_fifo: pop while empty");

endmodule

/* hw/rtl/cnv_front.sv */
// Front end: position counters, line stores, 3x3 window and region classification.
`timescale 1ns / 1ps

module cnv_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [cnv_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic                           i_frame_start,
    input  cnv_pkg::t_geom                 i_geom,
    input  logic [cnv_pkg::JOBQ_LVL_W-1:0] i_q_level,
    output logic                           o_job_push,
    output cnv_pkg::t_job                  o_job
);

    import cnv_pkg::*;

    // Sizes are limited by the parameters and by the 11-bit registers.
    localparam int LIM_W = (MAX_WIDTH  > 2047) ? 2047 : MAX_WIDTH;
    localparam int LIM_H = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam int AW    = $clog2(LIM_W);

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(3)) begin
            res = SIZE_W'(3);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Line stores.
    logic [PIX_W-1:0] r_line_upper  [LIM_W];
    logic [PIX_W-1:0] r_line_middle [LIM_W];
    logic [PIX_W-1:0] r_up_rd;
    logic [PIX_W-1:0] r_mid_rd;

    // Position state.
    logic [SIZE_W-1:0] r_col, r_row, n_col, n_row;

    // Stage A: the accepted pixel waiting for its line store data.
    logic              r_a_valid;
    logic              r_a_res;
    logic              r_a_last;
    logic [POS_W-1:0]  r_a_cx;
    logic [POS_W-1:0]  r_a_cy;
    logic [PIX_W-1:0]  r_a_pix;
    logic [AW-1:0]     r_a_addr;
    logic              r_a_fwd;
    logic [PIX_W-1:0]  r_a_fwd_val;

    logic [TAPS-1:0][PIX_W-1:0] r_win, n_win;

    logic              accept;
    logic [SIZE_W-1:0] w_sat, h_sat;
    logic [SIZE_W-1:0] c_cur, r_cur, c_inc, r_inc;
    logic [AW-1:0]     addr;
    logic [SIZE_W-1:0] sx, ex, sy, ey, cx, cy;
    logic              in_roi, is_last;
    logic [PIX_W-1:0]  top;

    assign w_sat  = sat_size(i_geom.width,  SIZE_W'(LIM_W));
    assign h_sat  = sat_size(i_geom.height, SIZE_W'(LIM_H));
    assign o_full = ({1'b0, i_q_level} + {{JOBQ_LVL_W{1'b0}}, (r_a_valid && r_a_res)})
                    >= (JOBQ_LVL_W + 1)'(JOBQ_DEPTH);
    assign accept = i_push && !o_full;

    // Position of the arriving pixel and of the one after it.
    always_comb begin
        c_cur = i_frame_start ? '0 : r_col;
        r_cur = i_frame_start ? '0 : r_row;
        if (c_cur >= w_sat) begin
            c_cur = '0;
            r_cur = r_cur + 1'b1;
        end
        if (r_cur >= h_sat) begin
            r_cur = '0;
        end
        c_inc = c_cur + 1'b1;
        r_inc = r_cur + 1'b1;
        if (c_inc >= w_sat) begin
            n_col = '0;
            n_row = (r_inc >= h_sat) ? '0 : r_inc;
        end else begin
            n_col = c_inc;
            n_row = r_cur;
        end
    end

    assign addr = c_cur[AW-1:0];

    // Region of interest clamped to the interior, and the window centre test.
    always_comb begin
        sx = i_geom.roi_x[SIZE_W-1:0];
        ex = i_geom.roi_x[16 +: SIZE_W];
        sy = i_geom.roi_y[SIZE_W-1:0];
        ey = i_geom.roi_y[16 +: SIZE_W];
        if (sx == '0) sx = SIZE_W'(1);
        if (sy == '0) sy = SIZE_W'(1);
        if (ex > w_sat - 1'b1) ex = w_sat - 1'b1;
        if (ey > h_sat - 1'b1) ey = h_sat - 1'b1;
        cx = c_cur - 1'b1;
        cy = r_cur - 1'b1;
        in_roi  = (c_cur >= SIZE_W'(2)) && (r_cur >= SIZE_W'(2)) &&
                  (cx >= sx) && (cx < ex) && (cy >= sy) && (cy < ey);
        is_last = (cx == ex - 1'b1) && (cy == ey - 1'b1);
    end

    // Upper store: read on accept, written in the next cycle with the middle data.
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_line_upper[r_a_addr] <= r_mid_rd;
        end
        if (accept) begin
            r_up_rd <= r_line_upper[addr];
        end
    end

    // Middle store: read the previous row and write the new pixel in the same cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid_rd <= r_line_middle[addr];
            r_line_middle[addr] <= i_pixel_in;
        end
    end

    // The upper write of the previous item is not yet in the store when the next item reads it, so forward it.
    assign top = r_a_fwd ? r_a_fwd_val : r_up_rd;

    // Window shift: each row moves left and takes the new column on the right.
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_mid_rd;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_a_pix;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_a_fwd   <= 1'b0;
            r_win     <= '0;
        end else begin
            r_a_valid <= accept;
            r_a_fwd   <= accept && r_a_valid && (r_a_addr == addr);
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_a_valid) begin
                r_win <= n_win;
            end
        end
    end

    // Stage A payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_res     <= in_roi;
            r_a_last    <= is_last;
            r_a_cx      <= cx[POS_W-1:0];
            r_a_cy      <= cy[POS_W-1:0];
            r_a_pix     <= i_pixel_in;
            r_a_addr    <= addr;
            r_a_fwd_val <= r_mid_rd;
        end
    end

    // Hand the completed window to the job queue.
    assign o_job_push = r_a_valid && r_a_res;
    always_comb begin
        o_job.win  = n_win;
        o_job.col  = r_a_cx;
        o_job.row  = r_a_cy;
        o_job.last = r_a_last;
    end

    // An accepted pixel always reaches stage A, and a job is only pushed with room to spare.
    a_accept_reaches_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid) else $error("cnv_front: accepted item lost");
    a_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (i_q_level < JOBQ_LVL_W'(JOBQ_DEPTH)))
        else $error("cnv_front: job pushed without room");

endmodule

/* hw/rtl/cnv_back.sv */
// Back end: weighted sum of the window, clamp and result queue.
`timescale 1ns / 1ps

module cnv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cnv_pkg::t_job    i_job,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  cnv_pkg::t_kernel i_kernel,
    output cnv_pkg::t_res    o_res,
    output logic             o_res_empty,
    input  logic             i_res_pop
);

    import cnv_pkg::*;

    // Stage P: nine products.
    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_p_prod [TAPS];
    logic [POS_W-1:0]         r_p_col, r_p_row;
    logic                     r_p_last;

    // Stage R: three row sums.
    logic                     r_r_valid;
    logic signed [SUM_W-1:0]  r_r_sum [3];
    logic [POS_W-1:0]         r_r_col, r_r_row;
    logic                     r_r_last;

    logic [OUTQ_LVL_W-1:0]    oq_level;
    logic                     oq_full;
    logic signed [SUM_W-1:0]  total;
    t_res                     res_in;

    // Take a job only if the result queue can hold everything in flight.
    assign o_job_pop = !i_job_empty &&
        (({1'b0, oq_level} + {{OUTQ_LVL_W{1'b0}}, r_p_valid}
          + {{OUTQ_LVL_W{1'b0}}, r_r_valid}) < (OUTQ_LVL_W + 1)'(OUTQ_DEPTH));

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_r_valid <= 1'b0;
        end else begin
            r_p_valid <= o_job_pop;
            r_r_valid <= r_p_valid;
        end
    end

    // Products: coefficient of tap k sits in bits 16(k%3)+15..16(k%3) of kernel row k/3.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            for (int k = 0; k < TAPS; k++) begin
                r_p_prod[k] <= PROD_W'($signed(i_kernel[k / 3][(k % 3) * COEF_W +: COEF_W])
                                       * $signed({1'b0, i_job.win[k]}));
            end
            r_p_col  <= i_job.col;
            r_p_row  <= i_job.row;
            r_p_last <= i_job.last;
        end
    end

    // Row sums.
    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_r_sum[i] <= SUM_W'(r_p_prod[3 * i]) + SUM_W'(r_p_prod[3 * i + 1])
                              + SUM_W'(r_p_prod[3 * i + 2]);
            end
            r_r_col  <= r_p_col;
            r_r_row  <= r_p_row;
            r_r_last <= r_p_last;
        end
    end

    // Final sum and clamp to the pixel range.
    assign total = r_r_sum[0] + r_r_sum[1] + r_r_sum[2];
    always_comb begin
        if (total[SUM_W-1]) begin
            res_in.pixel = '0;
        end else if (total > SUM_W'(PIX_MAX)) begin
            res_in.pixel = PIX_W'(PIX_MAX);
        end else begin
            res_in.pixel = total[PIX_W-1:0];
        end
        res_in.col  = r_r_col;
        res_in.row  = r_r_row;
        res_in.last = r_r_last;
    end

    // Result queue towards the output port.
    cnv_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_r_valid),
        .i_data  (res_in),
        .i_pop   (i_res_pop && !o_res_empty),
        .o_data  (o_res),
        .o_empty (o_res_empty),
        .o_full  (oq_full),
        .o_level (oq_level)
    );

    // Items in the arithmetic stages never outnumber the free result slots.
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, oq_level} + {{OUTQ_LVL_W{1'b0}}, r_p_valid} + {{OUTQ_LVL_W{1'b0}}, r_r_valid})
        <= (OUTQ_LVL_W + 1)'(OUTQ_DEPTH))
        else $error("cnv_back: result queue over-committed");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_valid |-> !oq_full) else $error("cnv_back: result pushed into full queue");

endmodule

/* dv/conv_checker.sv */
// Checker of the 3x3 saturating convolution filter: predicts every filtered pixel and compares.
`timescale 1ns / 1ps

module conv_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [cnv_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_frame_start,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  logic [cnv_pkg::PIX_W-1:0]     i_pixel_out,
    input  logic [cnv_pkg::POS_W-1:0]     i_out_col,
    input  logic [cnv_pkg::POS_W-1:0]     i_out_row,
    input  logic                          i_last_of_frame,
    input  logic                          i_cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cnv_pkg::KERN_W-1:0]    i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_checked
);
    import cnv_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Own copy of the registers.
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [ROI_W-1:0]  roi_x_reg;
    logic [ROI_W-1:0]  roi_y_reg;
    t_kernel           kernel;

    // Line stores, window and raster position as the filter keeps them.
    logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] window      [TAPS];
    int               col_pos;
    int               row_pos;

    t_res expected_pixels [$];
    t_res want;
    t_res got;

    function automatic int clamp_size(input int v, input int maxv);
        if (v < 3) return 3;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Moves one pixel through the line stores and window and queues the filtered
    // pixel when the completed window is centred inside the region.
    task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int w, h, c, r, sx, ex, sy, ey, cx, cy, sum, cf;
        logic [PIX_W-1:0] top_pix, mid_pix;
        t_res res;
        w = clamp_size(int'(width_reg), MAX_WIDTH);
        h = clamp_size(int'(height_reg), MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        // A column left over from a wider geometry starts the next row.
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        top_pix        = upper_line[c];
        mid_pix        = middle_line[c];
        upper_line[c]  = mid_pix;
        middle_line[c] = pix;
        for (int k = 0; k < TAPS; k += 3) begin
            window[k]     = window[k + 1];
            window[k + 1] = window[k + 2];
        end
        window[2] = top_pix;
        window[5] = mid_pix;
        window[8] = pix;

        // The region is clamped to the interior of the frame.
        sx = int'(roi_x_reg[10:0]);
        ex = int'(roi_x_reg[26:16]);
        sy = int'(roi_y_reg[10:0]);
        ey = int'(roi_y_reg[26:16]);
        if (sx < 1) sx = 1;
        if (sy < 1) sy = 1;
        if (ex > w - 1) ex = w - 1;
        if (ey > h - 1) ey = h - 1;

        if (c >= 2 && r >= 2) begin
            cx = c - 1;
            cy = r - 1;
            if (cx >= sx && cx < ex && cy >= sy && cy < ey) begin
                // Exact sum of signed coefficient times unsigned pixel, then clamped.
                sum = 0;
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        cf  = int'($signed(kernel[j][COEF_W*k +: COEF_W]));
                        sum += cf * int'(window[3*j + k]);
                    end
                end
                if (sum < 0) sum = 0;
                if (sum > PIX_MAX) sum = PIX_MAX;
                res.pixel = PIX_W'(sum);
                res.col   = POS_W'(cx);
                res.row   = POS_W'(cy);
                res.last  = (cx == ex - 1) && (cy == ey - 1);
                expected_pixels.push_back(res);
            end
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // All channels are sampled at the rising edge, before the block updates them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = SIZE_W'(256);
            height_reg = SIZE_W'(256);
            roi_x_reg  = ROI_W'(256) << 16;
            roi_y_reg  = ROI_W'(256) << 16;
            kernel     = '0;
            foreach (upper_line[n]) upper_line[n] = '0;
            foreach (middle_line[n]) middle_line[n] = '0;
            foreach (window[n]) window[n] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_pixels.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  width_reg  = i_cfg_data[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = i_cfg_data[SIZE_W-1:0];
                    REG_ROI_X:        roi_x_reg  = i_cfg_data[ROI_W-1:0];
                    REG_ROI_Y:        roi_y_reg  = i_cfg_data[ROI_W-1:0];
                    REG_KERNEL_ROW0:  kernel[0]  = i_cfg_data;
                    REG_KERNEL_ROW1:  kernel[1]  = i_cfg_data;
                    REG_KERNEL_ROW2:  kernel[2]  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) filter_pixel(i_pixel_in, i_frame_start);

            // Each result taken from the block is held against the oldest prediction.
            if (i_pop && !i_empty) begin
                got.pixel = i_pixel_out;
                got.col   = i_out_col;
                got.row   = i_out_row;
                got.last  = i_last_of_frame;
                if (expected_pixels.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result pix %0d col %0d row %0d last %0b",
                                 $time, got.pixel, got.col, got.row, got.last);
                end else begin
                    want = expected_pixels.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected pix %0d col %0d row %0d last %0b",
                                     $time, want.pixel, want.col, want.row, want.last);
                            $display("    got pix %0d col %0d row %0d last %0b",
                                     got.pixel, got.col, got.row, got.last);
                        end
                    end
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

/* dv/tb_top.sv */
// Testbench top of the 3x3 saturating convolution filter: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_top;
    import cnv_pkg::*;

    localparam int MAX_SIZE       = 1024;
    localparam int RANDOM_PIXELS  = 1000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ROI_W-1:0] ROI_ALL   = {11'h7FF, 5'h00, 11'h000};
    localparam logic [ROI_W-1:0] ROI_EMPTY = {ROI_W{1'b1}};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [PIX_W-1:0]     pixel_in;
    logic                 frame_start;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic [POS_W-1:0]     out_col;
    logic [POS_W-1:0]     out_row;
    logic                 last_of_frame;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [KERN_W-1:0]    cfg_data;

    int mismatches;
    int pending;
    int checked;

    int burst_left   = 0;
    int pixels_sent  = 0;
    int settings_run = 0;
    int filled_cols  = 0;   // columns already written twice in both line stores
    int cur_w        = 3;
    int cur_h        = 3;
    int quiet        = 0;
    int pop_mode     = 0;
    int pop_tick     = 0;

    always #5 clk = ~clk;

    conv3x3_saturating_filter #(
        .MAX_WIDTH  (MAX_SIZE),
        .MAX_HEIGHT (MAX_SIZE)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .push            (push),
        .full            (full),
        .i_pixel_in      (pixel_in),
        .i_frame_start   (frame_start),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_out     (pixel_out),
        .o_out_col       (out_col),
        .o_out_row       (out_row),
        .o_last_of_frame (last_of_frame),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    conv_checker #(
        .MAX_WIDTH  (MAX_SIZE),
        .MAX_HEIGHT (MAX_SIZE)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_pixel_in      (pixel_in),
        .i_frame_start   (frame_start),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_pixel_out     (pixel_out),
        .i_out_col       (out_col),
        .i_out_row       (out_row),
        .i_last_of_frame (last_of_frame),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    function automatic int usable_size(input int v);
        if (v < 3) return 3;
        if (v > MAX_SIZE) return MAX_SIZE;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Small, moderate or fully random coefficients, chosen per kernel row.
    function automatic logic [KERN_W-1:0] pick_kernel_row();
        logic [KERN_W-1:0] row;
        int spread, v;
        spread = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case (spread)
                0:       v = int'($urandom_range(0, 8)) - 4;
                1:       v = int'($urandom_range(0, 128)) - 64;
                default: v = int'($urandom_range(0, 65535));
            endcase
            row[COEF_W*k +: COEF_W] = v[COEF_W-1:0];
        end
        return row;
    endfunction

    // Regions near the frame size or random ones, which may be empty or inverted.
    function automatic logic [ROI_W-1:0] pick_roi(input int size);
        int lo, hi;
        logic [4:0] spare;
        spare = 5'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                lo = $urandom_range(0, 2);
                hi = $urandom_range(size - 1, 2047);
            end
            4, 5, 6, 7: begin
                lo = $urandom_range(0, size + 1);
                hi = $urandom_range(0, size + 1);
            end
            default: begin
                lo = $urandom_range(0, 2047);
                hi = $urandom_range(0, 2047);
            end
        endcase
        return {hi[10:0], spare, lo[10:0]};
    endfunction

    // One register write; bits above the register width sometimes carry junk.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KERN_W-1:0] value,
                           input int bits);
        logic [KERN_W-1:0] junk;
        junk = KERN_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0) junk = '0;
        cfg_idx  <= idx;
        cfg_data <= value | (junk & ({KERN_W{1'b1}} << bits));
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [SIZE_W-1:0] w_reg, h_reg,
                                 input logic [ROI_W-1:0] rx, ry, input t_kernel kern);
        cfg_we <= 1'b1;
        put_reg(REG_IMAGE_WIDTH,  KERN_W'(w_reg), SIZE_W);
        put_reg(REG_IMAGE_HEIGHT, KERN_W'(h_reg), SIZE_W);
        put_reg(REG_ROI_X,        KERN_W'(rx),    ROI_W);
        put_reg(REG_ROI_Y,        KERN_W'(ry),    ROI_W);
        put_reg(REG_KERNEL_ROW0,  kern[0],        KERN_W);
        put_reg(REG_KERNEL_ROW1,  kern[1],        KERN_W);
        put_reg(REG_KERNEL_ROW2,  kern[2],        KERN_W);
        cfg_we <= 1'b0;
        cur_w = usable_size(int'(w_reg));
        cur_h = usable_size(int'(h_reg));
        settings_run++;
    endtask

    // Sends one pixel in bursts of random length with random gaps between them.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        push        <= 1'b1;
        pixel_in    <= pix;
        frame_start <= fs;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    // A frame start now and then restarts the frame, but only once two full rows
    // have filled the line stores.
    task automatic stream_pixels(input int count, input bit with_start);
        logic fs;
        for (int n = 0; n < count; n++) begin
            fs = (n == 0) ? with_start : (n >= 2 * cur_w && $urandom_range(0, 99) < 2);
            send_pixel(pick_pixel(), fs);
        end
        if (with_start && cur_w > filled_cols) filled_cols = cur_w;
    endtask

    // Waits until every predicted result has come, then lets the pipeline run dry.
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The receiver switches at random among four stall patterns.
    always @(negedge clk) begin
        pop_tick++;
        if (pop_tick % 300 == 0) pop_mode = $urandom_range(0, 3);
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 1) == 1);
            2:       pop <= (pop_tick % 4 == 0);
            default: pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) quiet = 0;
        else quiet++;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("No item moved for %0d cycles, %0d results outstanding.", quiet, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int random_sent;
        int count;
        int w_eff;
        logic [SIZE_W-1:0] w_reg;
        logic [SIZE_W-1:0] h_reg;
        bit with_start;
        t_kernel kern;

        rst_n       = 1'b0;
        push        = 1'b0;
        pixel_in    = '0;
        frame_start = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Largest positive kernel on white pixels saturates high.
        apply_setting(11'd3, 11'd3, ROI_ALL, ROI_ALL, {3{48'h7FFF_7FFF_7FFF}});
        for (int n = 0; n < 9; n++) send_pixel('1, n == 0);
        settle();
        // Most negative kernel saturates low; with no frame start the counters wrap.
        apply_setting(11'd3, 11'd3, ROI_ALL, ROI_ALL, {3{48'h8000_8000_8000}});
        for (int n = 0; n < 9; n++) send_pixel((n % 2 == 1) ? '0 : '1, 1'b0);
        settle();
        // Inverted region: start beyond end, so nothing comes out.
        apply_setting(11'd3, 11'd3, ROI_EMPTY, ROI_EMPTY, {3{48'hFFFF_FFFF_FFFF}});
        for (int n = 0; n < 9; n++) send_pixel(PIX_W'(n * 29), n == 0);
        settle();

        // Oversized width register: the first part of one widest row, so no result.
        foreach (kern[j]) kern[j] = pick_kernel_row();
        apply_setting(11'h7FF, 11'd2, ROI_ALL, ROI_ALL, kern);
        for (int n = 0; n < 160; n++) send_pixel(pick_pixel(), n == 0);
        settle();
        // Undersized width and oversized height: a narrow strip of forty rows.
        foreach (kern[j]) kern[j] = pick_kernel_row();
        apply_setting(11'd0, 11'h7FF, ROI_ALL, ROI_ALL, kern);
        stream_pixels(cur_w * 40, 1'b1);
        settle();

        // Random geometries of small frames, whole frames plus a partial tail.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            w_reg = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(13, 40))
                                                : SIZE_W'($urandom_range(0, 12));
            h_reg = SIZE_W'($urandom_range(0, 10));
            w_eff = usable_size(int'(w_reg));
            // Sometimes no frame start, so a narrower frame picks up mid-row.
            with_start = !(w_eff <= filled_cols && $urandom_range(0, 3) == 0);
            foreach (kern[j]) kern[j] = pick_kernel_row();
            apply_setting(w_reg, h_reg, pick_roi(w_eff),
                          pick_roi(usable_size(int'(h_reg))), kern);
            count = $urandom_range(1, 3) * cur_w * cur_h + $urandom_range(0, 2 * cur_w);
            stream_pixels(count, with_start);
            random_sent += count;
            settle();
        end

        $display("Covered %0d pixels under %0d filter settings, out-of-range sizes too.",
                 pixels_sent, settings_run);
        $display("%0d filtered results were checked, %0d mismatches.", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
